// ----- hw/rtl/mat4_column_transform_top_assert.svh -----
// assertion macros for the column transform block
`ifndef MAT4_COLUMN_TRANSFORM_TOP_ASSERT_SVH
`define MAT4_COLUMN_TRANSFORM_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define M4_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication outside reset
`define M4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/m4ct_pkg.sv -----
`default_nettype none
package m4ct_pkg;
	localparam int unsigned DIM_DEF = 4;
	localparam int unsigned NFIELD = 4;
	localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_XFORM = 1'b1;

	typedef struct packed {
		logic        func;
		logic [1:0]  col_index;
		logic [31:0] e0;
		logic [31:0] e1;
		logic [31:0] e2;
		logic [31:0] e3;
	} in_item_t;

	typedef struct packed {
		logic [31:0] r0;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r3;
	} out_item_t;

	// unpacked float
	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        zero;
		logic        sgn;
		logic [9:0]  exp;   // signed biased exponent
		logic [23:0] man;   // with hidden bit
	} fp_t;

	function automatic logic is_nan(input logic [31:0] a);
		is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	// round a positive value: mantissa m (normalized, msb at bit 26 with guard/round/sticky
	// in bits 2:0), biased exponent e (may be <=0), to binary32
	function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
		input logic [26:0] m);
		logic [26:0]         mm;
		logic signed [11:0]  ee;
		logic [4:0]          sh;
		logic                st;
		logic [24:0]         r;
		logic [31:0]         res;
		mm = m;
		ee = e;
		if (ee <= 12'sd0) begin
			sh = (12'sd1 - ee > 12'sd26) ? 5'd26 : 5'(12'sd1 - ee);
			st = |(mm & ((27'd1 << sh) - 27'd1));
			mm = (mm >> sh) | {26'd0, st};
			ee = 12'sd0;
		end
		r = {1'b0, mm[26:3]};
		if (mm[2] && (mm[1] || mm[0] || mm[3]))
			r = r + 25'd1;
		if (r[24]) begin
			r = r >> 1;
			ee = ee + 12'sd1;
		end else if (ee == 12'sd0 && r[23]) begin
			ee = 12'sd1;
		end
		if (ee >= 12'sd255)
			res = {sgn, 8'hFF, 23'd0};
		else
			res = {sgn, ee[7:0], r[22:0]};
		fp_round = res;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/m4ct_if.sv -----
`default_nettype none
interface m4ct_in_if;
	logic              valid;
	logic              ready;
	m4ct_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface m4ct_out_if;
	logic               valid;
	logic               ready;
	m4ct_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mat4_column_transform_top.sv -----
`default_nettype none
// channel | dir | payload
// in_ch   | in  | func, col_index, e0..e3
// out_ch  | out | r0..r3
// one item per cycle while ready is high; a transform result is offered after the item has
// passed multiply, DIM-1 adder stages, queue write; a load takes effect for the next item
// reset restores the identity matrix in flip-flops at once
// stalls: a result queue of 2*DIM+2 entries; ready drops when the queue
// may fill, so no result is lost
module mat4_column_transform_top #(
	parameter int unsigned DIM = m4ct_pkg::DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	m4ct_in_if.sink    in_ch,
	m4ct_out_if.source out_ch
);
	localparam int unsigned LAT = DIM;          // pipeline stages to result
	localparam int unsigned QD  = 2 * DIM + 2;  // queue depth
	localparam int unsigned QW  = $clog2(QD + 1);
	localparam int unsigned PW  = $clog2(QD);

	logic [31:0] mat_q [DIM][DIM];   // [col][row]
	logic [31:0] elem  [DIM];
	logic        acc_in;
	logic        xf_v  [LAT];
	logic [QW-1:0] cnt_q;
	logic [QW-1:0] inflight;
	logic [PW-1:0] wp_q, rp_q;
	m4ct_pkg::out_item_t fifo_q [QD];
	m4ct_pkg::out_item_t res;
	logic [31:0] rows [4];

	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			case (k)
				0: elem[k] = in_ch.data.e0;
				1: elem[k] = in_ch.data.e1;
				2: elem[k] = in_ch.data.e2;
				3: elem[k] = in_ch.data.e3;
				default: elem[k] = 32'd0;
			endcase
		end
	end

	assign acc_in = in_ch.valid && in_ch.ready;

	// held left matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < DIM; c++)
				for (int r = 0; r < DIM; r++)
					mat_q[c][r] <= (c == r) ? m4ct_pkg::ONE_BITS : 32'd0;
		end else if (acc_in && in_ch.data.func == m4ct_pkg::FUNC_LOAD
			&& 32'(in_ch.data.col_index) < DIM) begin
			for (int c = 0; c < DIM; c++)
				if (c == 32'(in_ch.data.col_index))
					for (int r = 0; r < DIM; r++)
						mat_q[c][r] <= elem[r];
		end
	end

	// lanes, one per row
	for (genvar y = 0; y < DIM; y++) begin : g_lane
		logic [31:0] lft [DIM];
		logic [31:0] o;
		for (genvar k = 0; k < DIM; k++) begin : g_l
			assign lft[k] = mat_q[k][y];
		end
		m4ct_lane #(.DIM(DIM)) u_lane (.clk(clk), .en(1'b1), .rgt(elem), .lft(lft),
			.row_q(o));
		if (y < 4) begin : g_r
			assign rows[y] = o;
		end
	end
	for (genvar y = DIM; y < 4; y++) begin : g_z
		assign rows[y] = 32'd0;
	end

	// merge stage: canonical nan and pack
	always_comb begin
		res.r0 = m4ct_pkg::is_nan(rows[0]) ? m4ct_pkg::QNAN_BITS : rows[0];
		res.r1 = m4ct_pkg::is_nan(rows[1]) ? m4ct_pkg::QNAN_BITS : rows[1];
		res.r2 = m4ct_pkg::is_nan(rows[2]) ? m4ct_pkg::QNAN_BITS : rows[2];
		res.r3 = m4ct_pkg::is_nan(rows[3]) ? m4ct_pkg::QNAN_BITS : rows[3];
	end

	// valid tracking through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++)
				xf_v[i] <= 1'b0;
		end else begin
			xf_v[0] <= acc_in && in_ch.data.func == m4ct_pkg::FUNC_XFORM;
			for (int i = 1; i < LAT; i++)
				xf_v[i] <= xf_v[i-1];
		end
	end

	always_comb begin
		inflight = '0;
		for (int i = 0; i < LAT; i++)
			inflight = inflight + QW'(xf_v[i]);
	end

	assign in_ch.ready = (cnt_q + inflight) < QW'(QD - 1);

	// result queue
	logic push, pop;
	assign push = xf_v[LAT-1];
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= '0;
			rp_q  <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(QD - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PW'(QD - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + QW'(push) - QW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wp_q] <= res;
	end

	assign out_ch.valid = (cnt_q != '0);
	assign out_ch.data  = fifo_q[rp_q];

	`include "mat4_column_transform_top_assert.svh"
	`M4_ASSERT_IMP(a_no_overflow, push, cnt_q < QW'(QD) || pop, "result queue overflow")
	`M4_ASSERT_IMP(a_no_underflow, pop, cnt_q != '0, "result queue underflow")
	`M4_ASSERT_NEXT(a_cnt_track, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count slip")
endmodule
`default_nettype wire

// ----- hw/rtl/m4ct_fmul.sv -----
`default_nettype none
// binary32 multiply, round to nearest even, one register stage
module m4ct_fmul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] p_s1
);
	logic        sa, sb, sp;
	logic [7:0]  ea, eb;
	logic [23:0] ma, mb;
	logic [47:0] prod;
	logic [47:0] nrm;
	logic signed [11:0] ex;
	logic [5:0]  lz;
	logic [26:0] m27;
	logic [31:0] res;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

	always_comb begin
		sa = a[31];
		sb = b[31];
		sp = sa ^ sb;
		ea = a[30:23];
		eb = b[30:23];
		ma = {(ea != 8'd0), a[22:0]};
		mb = {(eb != 8'd0), b[22:0]};
		a_nan = m4ct_pkg::is_nan(a);
		b_nan = m4ct_pkg::is_nan(b);
		a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		prod = ma * mb;
		lz = 6'd0;
		for (int i = 47; i >= 0; i--) begin
			if (prod[i] && lz == 6'd0)
				lz = 6'(47 - i) + 6'd1;
		end
		// lz holds count+1 of leading zeros, 0 if product zero
		nrm = (lz == 6'd0) ? 48'd0 : prod << (lz - 6'd1);
		// value = prod * 2^(ea'+eb'-254-46); normalized msb at bit 47
		ex = 12'(signed'({4'd0, (ea == 8'd0) ? 8'd1 : ea}))
			+ 12'(signed'({4'd0, (eb == 8'd0) ? 8'd1 : eb}))
			- 12'sd126 - 12'(signed'({6'd0, lz})) + 12'sd1;
		m27 = {nrm[47:22], |nrm[21:0]};
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
			res = m4ct_pkg::QNAN_BITS;
		else if (a_inf || b_inf)
			res = {sp, 8'hFF, 23'd0};
		else if (a_zero || b_zero)
			res = {sp, 31'd0};
		else
			res = m4ct_pkg::fp_round(sp, ex, m27);
	end

	always_ff @(posedge clk) begin
		if (en)
			p_s1 <= res;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/m4ct_fadd.sv -----
`default_nettype none
// binary32 add, round to nearest even, one register stage
module m4ct_fadd (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [31:0] s_s1
);
	logic        swap;
	logic [31:0] x, y;
	logic [7:0]  ex, ey;
	logic [26:0] mx, my, my_sh;
	logic [8:0]  d;
	logic        st;
	logic [27:0] sum;
	logic        sub;
	logic [4:0]  lz;
	logic [27:0] nrm;
	logic signed [11:0] e;
	logic [31:0] res;
	logic        xi, yi;

	always_comb begin
		swap = (b[30:0] > a[30:0]);
		x = swap ? b : a;
		y = swap ? a : b;
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {(x[30:23] != 8'd0), x[22:0], 3'd0};
		my = {(y[30:23] != 8'd0), y[22:0], 3'd0};
		d = {1'b0, ex} - {1'b0, ey};
		if (d > 9'd26) begin
			st = |my;
			my_sh = {26'd0, st};
		end else begin
			st = |(my & ((27'd1 << d[4:0]) - 27'd1));
			my_sh = (my >> d[4:0]) | {26'd0, st};
		end
		sub = x[31] ^ y[31];
		sum = sub ? ({1'b0, mx} - {1'b0, my_sh}) : ({1'b0, mx} + {1'b0, my_sh});
		lz = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (sum[i])
				lz = 5'(27 - i);
		end
		e = 12'(signed'({4'd0, ex})) + 12'sd1 - 12'(signed'({7'd0, lz}));
		if (e < 12'sd1) begin
			// subnormal range: exact, bit 27 aligned to biased exponent 0
			nrm = sum << (5'(ex) + 5'd1);
			e = 12'sd0;
		end else begin
			nrm = sum << lz;
		end
		xi = (x[30:23] == 8'hFF);
		yi = (y[30:23] == 8'hFF);
		if (m4ct_pkg::is_nan(a) || m4ct_pkg::is_nan(b))
			res = m4ct_pkg::QNAN_BITS;
		else if (xi && yi && sub)
			res = m4ct_pkg::QNAN_BITS;
		else if (xi)
			res = x;
		else if (sum == 28'd0)
			res = {(x[31] & y[31]), 31'd0};
		else
			res = m4ct_pkg::fp_round(x[31], e, {nrm[27:2], |nrm[1:0]});
	end

	always_ff @(posedge clk) begin
		if (en)
			s_s1 <= res;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/m4ct_lane.sv -----
`default_nettype none
// one result row: DIM multipliers, then a chain of DIM-1 adders
module m4ct_lane #(
	parameter int unsigned DIM = m4ct_pkg::DIM_DEF
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [31:0]     rgt [DIM],
	input  wire logic [31:0]     lft [DIM],
	output logic      [31:0]     row_q
);
	logic [31:0] prod_s1 [DIM];
	logic [31:0] prod_d  [DIM][DIM];
	logic [31:0] acc     [DIM];

	for (genvar k = 0; k < DIM; k++) begin : g_mul
		m4ct_fmul u_mul (.clk(clk), .en(en), .a(rgt[k]), .b(lft[k]), .p_s1(prod_s1[k]));
	end

	// delay line aligns product k with adder stage k
	always_ff @(posedge clk) begin
		for (int k = 0; k < DIM; k++) begin
			prod_d[k][0] <= prod_s1[k];
			for (int j = 1; j < DIM; j++)
				prod_d[k][j] <= prod_d[k][j-1];
		end
	end

	assign acc[0] = prod_s1[0];
	for (genvar k = 1; k < DIM; k++) begin : g_add
		if (k == 1) begin : g_near
			m4ct_fadd u_add (.clk(clk), .en(en), .a(acc[k-1]), .b(prod_s1[k]),
				.s_s1(acc[k]));
		end else begin : g_far
			m4ct_fadd u_add (.clk(clk), .en(en), .a(acc[k-1]), .b(prod_d[k][k-2]),
				.s_s1(acc[k]));
		end
	end

	assign row_q = acc[DIM-1];
endmodule
`default_nettype wire

// ----- sim/mat4_column_transform_top_tb.sv -----
`timescale 1ns / 1ps
module mat4_column_transform_top_tb;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;

	m4ct_in_if in_ch();
	m4ct_out_if out_ch();

	mat4_column_transform_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// held left matrix, indexed [column][row]
	logic [31:0] left_m [4][4];
	m4ct_pkg::out_item_t expected_cols [$];
	int err_count;
	int cyc;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit, counted in cycles
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// binary32 bits to a double value (exact)
	function automatic real f32_to_real(input logic [31:0] w);
		logic [63:0] d;
		logic [23:0] m;
		int ex;
		d = '0;
		d[63] = w[31];
		m = {1'b0, w[22:0]};
		if (w[30:23] == 8'hFF) begin
			d[62:52] = 11'h7FF;
			d[51:0] = {w[22:0], 29'd0};
		end else if (w[30:23] == 8'h00) begin
			if (m != 0) begin
				ex = -126;
				while (!m[23]) begin
					m = m << 1;
					ex = ex - 1;
				end
				d[62:52] = 11'(ex + 1023);
				d[51:0] = {m[22:0], 29'd0};
			end
		end else begin
			d[62:52] = 11'(int'(w[30:23]) - 127 + 1023);
			d[51:0] = {w[22:0], 29'd0};
		end
		return $bitstoreal(d);
	endfunction

	// round a double to binary32 with nearest-even; nans come out canonical
	function automatic logic [31:0] real_to_f32(input real v);
		logic [63:0] d;
		logic [63:0] full;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		int fe;
		int sh;
		d = $realtobits(v);
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 0) ? m4ct_pkg::QNAN_BITS : {d[63], 8'hFF, 23'd0};
		// double subnormals lie far below the binary32 range
		if (d[62:52] == 11'h000)
			return {d[63], 31'd0};
		fe = int'(d[62:52]) - 1023 + 127;
		full = {11'd0, 1'b1, d[51:0]};
		sh = (fe >= 1) ? 29 : 29 + 1 - fe;
		if (sh > 62)
			sh = 62;
		q = full >> sh;
		rem = full & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 64'd1;
		if (fe >= 1) begin
			if (q[24]) begin
				q = q >> 1;
				fe = fe + 1;
			end
			if (fe >= 255)
				return {d[63], 8'hFF, 23'd0};
			return {d[63], 8'(fe), q[22:0]};
		end
		// subnormal; a carry into bit 23 lands on the smallest normal
		return {d[63], q[30:0]};
	endfunction

	// one result column: products rounded, summed left to right
	function automatic m4ct_pkg::out_item_t transform_column(input m4ct_pkg::in_item_t it);
		logic [31:0] rc [4];
		logic [31:0] res [4];
		logic [31:0] prod;
		logic [31:0] acc;
		m4ct_pkg::out_item_t o;
		rc[0] = it.e0;
		rc[1] = it.e1;
		rc[2] = it.e2;
		rc[3] = it.e3;
		for (int y = 0; y < 4; y++) begin
			acc = real_to_f32(f32_to_real(rc[0]) * f32_to_real(left_m[0][y]));
			for (int k = 1; k < 4; k++) begin
				prod = real_to_f32(f32_to_real(rc[k]) * f32_to_real(left_m[k][y]));
				acc = real_to_f32(f32_to_real(acc) + f32_to_real(prod));
			end
			res[y] = acc;
		end
		o.r0 = res[0];
		o.r1 = res[1];
		o.r2 = res[2];
		o.r3 = res[3];
		return o;
	endfunction

	// track accepted items: loads update the matrix, transforms queue a column
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (in_ch.data.func == m4ct_pkg::FUNC_LOAD) begin
				left_m[in_ch.data.col_index][0] = in_ch.data.e0;
				left_m[in_ch.data.col_index][1] = in_ch.data.e1;
				left_m[in_ch.data.col_index][2] = in_ch.data.e2;
				left_m[in_ch.data.col_index][3] = in_ch.data.e3;
			end else begin
				expected_cols.push_back(transform_column(in_ch.data));
			end
		end
	end

	// compare each result with the oldest expected column
	always @(posedge clk) begin
		m4ct_pkg::out_item_t want;
		m4ct_pkg::out_item_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_cols.size() == 0) begin
				$error("result with nothing expected: %h", got);
				err_count++;
			end else begin
				want = expected_cols.pop_front();
				if (got.r0 !== want.r0) begin
					$error("r0 expected %h actual %h", want.r0, got.r0);
					err_count++;
				end
				if (got.r1 !== want.r1) begin
					$error("r1 expected %h actual %h", want.r1, got.r1);
					err_count++;
				end
				if (got.r2 !== want.r2) begin
					$error("r2 expected %h actual %h", want.r2, got.r2);
					err_count++;
				end
				if (got.r3 !== want.r3) begin
					$error("r3 expected %h actual %h", want.r3, got.r3);
					err_count++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one item, wait for it to be taken; valid stays high afterwards
	task automatic send_item(input m4ct_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	function automatic m4ct_pkg::in_item_t make_item(input logic f, input logic [1:0] c,
		input logic [31:0] a, input logic [31:0] b, input logic [31:0] x, input logic [31:0] z);
		m4ct_pkg::in_item_t it;
		it.func = f;
		it.col_index = c;
		it.e0 = a;
		it.e1 = b;
		it.e2 = x;
		it.e3 = z;
		return it;
	endfunction

	// element mix: special values, tame magnitudes, and raw bit patterns
	function automatic logic [31:0] rand_elem();
		logic [31:0] w;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(7))
					0: w = 32'h0000_0000;
					1: w = 32'h8000_0000;
					2: w = 32'h7F80_0000;
					3: w = 32'hFF80_0000;
					4: w = {1'($urandom), 8'hFF, 23'($urandom | 1)};
					5: w = {1'($urandom), 8'h00, 23'($urandom)};
					6: w = {1'($urandom), 8'hFE, 23'($urandom)};
					default: w = m4ct_pkg::ONE_BITS;
				endcase
			end
			1, 2: w = $urandom;
			3: w = {1'($urandom), 8'($urandom_range(1, 30)), 23'($urandom)};
			4: w = {1'($urandom), 8'($urandom_range(225, 254)), 23'($urandom)};
			default: w = {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
		endcase
		return w;
	endfunction

	function automatic m4ct_pkg::in_item_t rand_item(input int load_pct);
		m4ct_pkg::in_item_t it;
		it.func = ($urandom_range(99) < load_pct) ? m4ct_pkg::FUNC_LOAD : m4ct_pkg::FUNC_XFORM;
		it.col_index = 2'($urandom);
		it.e0 = rand_elem();
		it.e1 = rand_elem();
		it.e2 = rand_elem();
		it.e3 = rand_elem();
		return it;
	endfunction

	// wait until every expected column is back, then let the pipe settle
	task automatic drain();
		in_ch.valid = 1'b0;
		while (expected_cols.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// identity after reset: transforms pass the column through, with edge values
	task automatic test_reset_identity();
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd0, m4ct_pkg::ONE_BITS, 32'h4000_0000,
			32'hC040_0000, 32'h0000_0000));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd3, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
			32'h0000_0001, 32'h8000_0001));
		// nan payloads come back canonical, inf times zero too
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd1, 32'h7F80_0001, 32'hFFFF_FFFF,
			32'h7F80_0000, 32'hFF80_0000));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd2, 32'h8000_0000, 32'h007F_FFFF,
			32'h0080_0000, 32'hFFFF_FFFF));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd0, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h0000_0000, 32'hFFFF_FFFF));
		drain();
	endtask

	// loads into every column, then transforms that hit overflow, cancellation and rounding
	task automatic test_loads();
		send_item(make_item(m4ct_pkg::FUNC_LOAD, 2'd0, 32'h7F7F_FFFF, 32'h3F80_0000,
			32'h0000_0001, 32'h7F80_0000));
		send_item(make_item(m4ct_pkg::FUNC_LOAD, 2'd1, 32'h7F7F_FFFF, 32'hBF80_0000,
			32'h0000_0001, 32'h0000_0000));
		send_item(make_item(m4ct_pkg::FUNC_LOAD, 2'd2, 32'h3400_0000, 32'h3F80_0001,
			32'h8080_0000, 32'hFFFF_FFFF));
		send_item(make_item(m4ct_pkg::FUNC_LOAD, 2'd3, 32'h3F80_0000, 32'h3300_0000,
			32'h3F00_0000, 32'h5555_5555));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd0, m4ct_pkg::ONE_BITS, m4ct_pkg::ONE_BITS,
			m4ct_pkg::ONE_BITS, m4ct_pkg::ONE_BITS));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd0, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h8000_0000));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd0, 32'h4000_0000, 32'h4000_0000,
			32'h3F00_0000, 32'h3F80_0000));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd0, 32'h3F00_0000, 32'h3F00_0000,
			32'h0080_0000, 32'hFFFF_FFFF));
		// load directly followed by a transform that uses it
		send_item(make_item(m4ct_pkg::FUNC_LOAD, 2'd0, 32'h4040_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0000));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd3, m4ct_pkg::ONE_BITS, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0000));
		send_item(make_item(m4ct_pkg::FUNC_LOAD, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(m4ct_pkg::FUNC_XFORM, 2'd1, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, m4ct_pkg::ONE_BITS));
		drain();
	endtask

	task automatic test_random(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) send_item(rand_item(20));
		drain();
	endtask

	// receiver holds off while the sender keeps offering, so the input must stall
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		hold_left = 300;
		repeat (60) send_item(rand_item(10));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		err_count = 0;
		cyc = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				left_m[c][r] = (c == r) ? m4ct_pkg::ONE_BITS : 32'h0000_0000;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_identity();
		test_loads();
		test_random(520, 30, 65);
		test_random(520, 65, 30);
		test_random(500, 0, 0);
		test_backpressure();

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
